>>> hdl/ticketed_two_class_priority_queues_unit_assert.svh
// assertion macros shared by the ticket queue checker
`ifndef TICKETED_TWO_CLASS_PRIORITY_QUEUES_UNIT_ASSERT_SVH
`define TICKETED_TWO_CLASS_PRIORITY_QUEUES_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TCPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tcpq_pkg.sv
// shared types and constants of the ticket queue unit
`timescale 1ns / 1ps
package tcpq_pkg;

  localparam int unsigned SERVICE_W   = 4;
  localparam int unsigned TICKET_W    = 32;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_JOIN = 2'd0,
    OP_GET  = 2'd1,
    OP_BAD  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    op_e                  op;
    logic [SERVICE_W-1:0] service;
    logic                 vip;
  } cmd_t;

endpackage

>>> hdl/tcpq_cmd_fifo.sv
// two-entry command queue between the front and back parts
`timescale 1ns / 1ps
module tcpq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcpq_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tcpq_pkg::cmd_t pop_cmd_o
);
  import tcpq_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/tcpq_front.sv
// request intake: handshake and classification into commands
`timescale 1ns / 1ps
module tcpq_front #(
  parameter int unsigned SERVICES = 8
) (
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [tcpq_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic                                s_tuser_i,
  input  logic                                fifo_full_i,
  output logic                                push_o,
  output tcpq_pkg::cmd_t                      cmd_o
);
  import tcpq_pkg::*;

  localparam logic [SERVICE_W:0] SvcLimit = (SERVICE_W + 1)'(SERVICES);

  logic [SERVICE_W-1:0] service;
  logic                 vip;
  logic                 bad_svc;

  assign service = s_tdata_i[SERVICE_W-1:0];
  assign vip     = s_tdata_i[SERVICE_W];
  assign bad_svc = ({1'b0, service} >= SvcLimit);

  assign s_tready_o = !fifo_full_i;
  assign push_o     = s_tvalid_i && !fifo_full_i;

  always_comb begin
    cmd_o.service = service;
    cmd_o.vip     = vip;
    if (bad_svc) begin
      cmd_o.op = OP_BAD;
    end else if (s_tuser_i) begin
      cmd_o.op = OP_GET;
    end else begin
      cmd_o.op = OP_JOIN;
    end
  end

endmodule

>>> hdl/tcpq_back.sv
// command execution: ticket counter, queue pointers, ticket memory, result register
`timescale 1ns / 1ps
module tcpq_back #(
  parameter int unsigned SERVICES    = 8,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  tcpq_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [tcpq_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output logic [1:0]                       m_tuser_o
);
  import tcpq_pkg::*;

  localparam int unsigned SVC_W     = (SERVICES > 1) ? $clog2(SERVICES) : 1;
  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = SERVICES * 2 * (2 ** PTR_W);
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned FULL_AW   = SVC_W + 1 + PTR_W;
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_OUT  = 3'b100
  } bk_state_e;

  bk_state_e            state_q, state_d;
  logic [TICKET_W-1:0]  next_tk_q, next_tk_d;
  status_e              status_q, status_d;
  logic [TICKET_W-1:0]  ticket_q, ticket_d;
  logic                 tvip_q, tvip_d;

  logic [PTR_W-1:0]     head_q [SERVICES][2];
  logic [PTR_W-1:0]     tail_q [SERVICES][2];
  logic [CNT_W-1:0]     cnt_q  [SERVICES][2];

  logic [TICKET_W-1:0]  mem_q [MEM_DEPTH];
  logic [TICKET_W-1:0]  rd_data_q;

  logic [SVC_W-1:0]     svc_idx;
  logic                 cls;
  logic [CNT_W-1:0]     cnt_vip, cnt_norm, cnt_sel;
  logic [PTR_W-1:0]     head_sel, tail_sel, slot;
  logic [FULL_AW-1:0]   addr_full;
  logic [MEM_AW-1:0]    mem_addr;
  logic                 mem_we, mem_re;
  logic                 head_adv, tail_adv;

  assign svc_idx  = cmd_i.service[SVC_W-1:0];
  assign cnt_vip  = cnt_q[svc_idx][1];
  assign cnt_norm = cnt_q[svc_idx][0];

  // join picks its class from the request, get prefers a waiting vip ticket
  assign cls      = (cmd_i.op == OP_JOIN) ? cmd_i.vip : (cnt_vip != '0);
  assign cnt_sel  = cls ? cnt_vip : cnt_norm;
  assign head_sel = head_q[svc_idx][cls];
  assign tail_sel = tail_q[svc_idx][cls];
  assign slot     = (cmd_i.op == OP_JOIN) ? tail_sel : head_sel;
  assign addr_full = {svc_idx, cls, slot};
  assign mem_addr  = addr_full[MEM_AW-1:0];

  always_comb begin
    state_d   = state_q;
    next_tk_d = next_tk_q;
    status_d  = status_q;
    ticket_d  = ticket_q;
    tvip_d    = tvip_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    head_adv  = 1'b0;
    tail_adv  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          tvip_d    = 1'b0;
          state_d   = BK_OUT;
          case (cmd_i.op)
            OP_JOIN: begin
              ticket_d  = next_tk_q;
              next_tk_d = next_tk_q + 1'b1;
              if (cnt_sel == CntFull) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_OK;
                mem_we   = 1'b1;
                tail_adv = 1'b1;
              end
            end
            OP_GET: begin
              if (cnt_sel != '0) begin
                status_d = ST_OK;
                tvip_d   = cls;
                mem_re   = 1'b1;
                head_adv = 1'b1;
                state_d  = BK_READ;
              end else begin
                status_d = ST_EMPTY;
                ticket_d = '0;
              end
            end
            default: begin
              status_d = ST_BAD;
              ticket_d = '0;
            end
          endcase
        end
      end
      BK_READ: begin
        ticket_d = rd_data_q;
        state_d  = BK_OUT;
      end
      BK_OUT: begin
        if (m_tready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      next_tk_q <= '0;
      status_q  <= ST_OK;
      ticket_q  <= '0;
      tvip_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_tk_q <= next_tk_d;
      status_q  <= status_d;
      ticket_q  <= ticket_d;
      tvip_q    <= tvip_d;
    end
  end

  // per-queue pointers and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SERVICES; s++) begin
        for (int c = 0; c < 2; c++) begin
          head_q[s][c] <= '0;
          tail_q[s][c] <= '0;
          cnt_q[s][c]  <= '0;
        end
      end
    end else begin
      if (tail_adv) begin
        tail_q[svc_idx][cls] <= (tail_sel == PtrLast) ? '0 : tail_sel + 1'b1;
        cnt_q[svc_idx][cls]  <= cnt_sel + 1'b1;
      end
      if (head_adv) begin
        head_q[svc_idx][cls] <= (head_sel == PtrLast) ? '0 : head_sel + 1'b1;
        cnt_q[svc_idx][cls]  <= cnt_sel - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= next_tk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  assign m_tvalid_o = (state_q == BK_OUT);
  assign m_tdata_o  = {(OUT_TDATA_W - TICKET_W - 1)'(0), tvip_q, ticket_q};
  assign m_tuser_o  = status_q;

endmodule

>>> hdl/ticketed_two_class_priority_queues_unit.sv
// top level of the ticketed two-class priority queue unit
`timescale 1ns / 1ps
// Ticket dispenser with SERVICES services, each owning a vip and a normal
// fifo of QUEUE_DEPTH tickets. A join (tuser 0) draws the next ticket from a
// free-running 32-bit counter and appends it to the chosen fifo; a full fifo
// still burns the ticket and returns status full. A get (tuser 1) pops the
// oldest vip ticket of the service, else the oldest normal one, else returns
// status empty with ticket 0. A service index at or above SERVICES gets
// status bad service and does not touch the counter. Every request beat
// yields exactly one result beat, in order. Timing: the intake classifies a
// request and parks it in a two-entry command queue, so the input side keeps
// taking beats while a result waits, until that queue is full. A join, a
// rejected request or an empty get goes from idle straight to the output
// state; a get that pops passes through a read state first (the read of the
// single-port ticket memory is registered). The result is then held until it
// is taken, and no new command is popped before that. The memory needs no
// clearing after reset: slots are only read once written.
module ticketed_two_class_priority_queues_unit #(
  parameter int unsigned SERVICES    = 8,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request side
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [tcpq_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // service[3:0], vip[4], zero fill
  input  logic                                s_axis_tuser_i,   // kind: 0 join, 1 get work
  // result side
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [tcpq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // ticket[31:0], ticket_vip[32], zero fill
  output logic [1:0]                          m_axis_tuser_o    // status
);
  import tcpq_pkg::*;

  logic fifo_full;
  logic push;
  cmd_t push_cmd;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // intake: handshake and request classification
  tcpq_front #(
    .SERVICES(SERVICES)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decoupling queue between intake and execution
  tcpq_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (fifo_full),
    .pop_i     (cmd_pop),
    .valid_o   (cmd_valid),
    .pop_cmd_o (cmd)
  );

  // execution: counter, fifos, ticket memory and result register
  tcpq_back #(
    .SERVICES   (SERVICES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> hdl/tcpq_checker.sv
// port-level checks of the result stream, bound to the top level
`timescale 1ns / 1ps
`include "ticketed_two_class_priority_queues_unit_assert.svh"
module tcpq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [tcpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]                       m_axis_tuser_o
);
  import tcpq_pkg::*;

  `TCPQ_ASSERT_NOW(a_bad_zero, m_axis_tvalid_o && (m_axis_tuser_o == ST_BAD), m_axis_tdata_o == '0, "bad service beat carries data")
  `TCPQ_ASSERT_NOW(a_empty_zero, m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY), m_axis_tdata_o == '0, "empty get beat carries data")
  `TCPQ_ASSERT_NOW(a_full_novip, m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL), !m_axis_tdata_o[TICKET_W], "full join beat flags vip")
  `TCPQ_ASSERT_NEXT(a_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result beat changed")

endmodule

bind ticketed_two_class_priority_queues_unit tcpq_checker u_tcpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

>>> verif/ticketed_two_class_priority_queues_unit_checker.sv
// checker that predicts and compares the ticket queue unit's result beats
`timescale 1ns / 1ps
module ticketed_two_class_priority_queues_unit_checker
  import tcpq_pkg::*;
#(
  parameter int unsigned SERVICES    = 8,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // service[3:0], vip[4], zero fill
  input  logic                   s_axis_tuser_i,   // kind: 0 join, 1 get work
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // ticket[31:0], ticket_vip[32], zero fill
  input  logic [1:0]             m_axis_tuser_i,   // status
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int unsigned LANES = 2 * SERVICES;

  typedef struct {
    status_e             status;
    logic [TICKET_W-1:0] ticket;
    logic                vip;
  } ticket_result_t;

  // shadow state: ticket counter and one fifo per service and class
  logic [TICKET_W-1:0] ticket_counter;
  logic [TICKET_W-1:0] lane_fifo [LANES][$];
  ticket_result_t      due_results[$];
  int                  fail_count;

  function automatic ticket_result_t serve_request(input logic get_work,
                                                   input logic [SERVICE_W-1:0] service,
                                                   input logic vip);
    ticket_result_t      res;
    int unsigned         lane;
    logic [TICKET_W-1:0] issued;
    res = '{ST_OK, '0, 1'b0};
    if (service >= SERVICES) begin
      res.status = ST_BAD;
    end else if (op_e'({1'b0, get_work}) == OP_JOIN) begin
      lane           = service * 2 + vip;
      issued         = ticket_counter;
      ticket_counter = ticket_counter + 1'b1;
      res.ticket     = issued;
      // a full fifo still burns the ticket
      if (lane_fifo[lane].size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        lane_fifo[lane].push_back(issued);
      end
    end else if (lane_fifo[service * 2 + 1].size() != 0) begin
      res.ticket = lane_fifo[service * 2 + 1].pop_front();
      res.vip    = 1'b1;
    end else if (lane_fifo[service * 2].size() != 0) begin
      res.ticket = lane_fifo[service * 2].pop_front();
    end else begin
      res.status = ST_EMPTY;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ticket_result_t due;
    status_e        got_status;
    logic           got_vip;
    logic [TICKET_W-1:0] got_ticket;
    if (!rst_ni) begin
      ticket_counter = '0;
      foreach (lane_fifo[i]) lane_fifo[i].delete();
      due_results.delete();
      fail_count     = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        due_results.push_back(serve_request(s_axis_tuser_i,
                                            s_axis_tdata_i[SERVICE_W-1:0],
                                            s_axis_tdata_i[SERVICE_W]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_status = status_e'(m_axis_tuser_i);
        got_ticket = m_axis_tdata_i[TICKET_W-1:0];
        got_vip    = m_axis_tdata_i[TICKET_W];
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no request waiting, expected none, got %s %0d %0b",
                   $time, got_status.name(), got_ticket, got_vip);
        end else begin
          due = due_results.pop_front();
          if (got_status !== due.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %s, got %s",
                     $time, due.status.name(), got_status.name());
          end
          if (got_ticket !== due.ticket) begin
            fail_count++;
            $display("%0t: ticket mismatch, expected %0d, got %0d",
                     $time, due.ticket, got_ticket);
          end
          if (got_vip !== due.vip) begin
            fail_count++;
            $display("%0t: ticket_vip mismatch, expected %0b, got %0b",
                     $time, due.vip, got_vip);
          end
        end
      end
      fail_count_o <= fail_count;
      pending_o    <= due_results.size();
    end
  end

endmodule

>>> verif/tb_ticketed_two_class_priority_queues_unit.sv
// testbench top: request stimulus, result sink, watchdog and verdict
`timescale 1ns / 1ps
module tb_ticketed_two_class_priority_queues_unit;
  import tcpq_pkg::*;

  localparam int unsigned SERVICES      = 8;
  localparam int unsigned QUEUE_DEPTH   = 64;
  localparam int unsigned RANDOM_REQS   = 1550;
  localparam int unsigned IDLE_PCT      = 6;
  localparam int unsigned BAD_PCT       = 6;
  localparam int unsigned PAUSE_AT      = 700;   // sender drains the unit here
  localparam int unsigned CALM_FROM     = 1000;  // sender never idles in this span
  localparam int unsigned CALM_TO       = 1250;
  localparam int unsigned HOLD_AT       = 1500;  // sink cycle where the long hold-off starts
  localparam int unsigned HOLD_LEN      = 250;
  localparam int unsigned SINK_CALM_LO  = 3000;  // sink never idles in this span
  localparam int unsigned SINK_CALM_HI  = 3800;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned SERVICE_MAX   = (1 << SERVICE_W) - 1;

  typedef enum int {
    MODE_MIXED,
    MODE_FILL,
    MODE_DRAIN
  } traffic_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // service[3:0], vip[4], zero fill
  logic                   s_axis_tuser_i;   // kind: 0 join, 1 get work
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // ticket[31:0], ticket_vip[32], zero fill
  logic [1:0]             m_axis_tuser_o;   // status
  int                     fail_count;
  int                     pending;
  int unsigned            stall_cycles;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ticketed_two_class_priority_queues_unit #(
    .SERVICES   (SERVICES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  ticketed_two_class_priority_queues_unit_checker #(
    .SERVICES   (SERVICES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // offer one request beat, hold it until taken, then maybe drop valid for a gap
  task automatic push_request(input op_e op, input logic [SERVICE_W-1:0] service,
                              input logic vip, input bit no_gaps);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - SERVICE_W - 1){1'b0}}, vip, service};
    s_axis_tuser_i  <= (op == OP_GET);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (!no_gaps && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
  endtask

  // request side
  initial begin
    traffic_mode_e        mode;
    int unsigned          seg_left;
    logic [SERVICE_W-1:0] focus_service;
    logic                 focus_vip;
    op_e                  op;
    logic [SERVICE_W-1:0] service;
    logic                 vip;
    int unsigned          roll;
    int unsigned          join_pct;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    mode            = MODE_MIXED;
    seg_left        = 0;
    focus_service   = '0;
    focus_vip       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty get, vip before normal, fifo order, vip ignored on get,
    // rejected services that burn no ticket, highest valid service
    push_request(OP_GET,  4'd0,  1'b0, 1'b0);
    push_request(OP_JOIN, 4'd0,  1'b0, 1'b0);
    push_request(OP_JOIN, 4'd0,  1'b1, 1'b0);
    push_request(OP_JOIN, 4'd0,  1'b0, 1'b0);
    push_request(OP_GET,  4'd0,  1'b0, 1'b0);
    push_request(OP_GET,  4'd0,  1'b1, 1'b0);
    push_request(OP_GET,  4'd0,  1'b0, 1'b0);
    push_request(OP_GET,  4'd0,  1'b0, 1'b0);
    push_request(OP_JOIN, 4'd8,  1'b0, 1'b0);
    push_request(OP_JOIN, 4'd15, 1'b1, 1'b0);
    push_request(OP_GET,  4'd15, 1'b0, 1'b0);
    push_request(OP_GET,  4'd8,  1'b1, 1'b0);
    push_request(OP_JOIN, 4'd7,  1'b1, 1'b0);
    push_request(OP_JOIN, 4'd7,  1'b0, 1'b0);
    push_request(OP_GET,  4'd7,  1'b0, 1'b0);
    push_request(OP_GET,  4'd7,  1'b1, 1'b0);
    push_request(OP_JOIN, 4'd5,  1'b0, 1'b0);
    push_request(OP_GET,  4'd5,  1'b1, 1'b0);
    push_request(OP_GET,  4'd10, 1'b1, 1'b0);
    push_request(OP_GET,  4'd7,  1'b0, 1'b0);

    // random: segments that fill one fifo past its depth, drain, or mix
    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      if (n == PAUSE_AT) begin
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      if (seg_left == 0) begin
        seg_left      = $urandom_range(120, 30);
        mode          = traffic_mode_e'($urandom_range(MODE_DRAIN, MODE_MIXED));
        focus_service = SERVICE_W'($urandom_range(SERVICES - 1, 0));
        focus_vip     = 1'($urandom_range(1, 0));
      end
      seg_left--;
      case (mode)
        MODE_FILL:  join_pct = 90;
        MODE_DRAIN: join_pct = 20;
        default:    join_pct = 50;
      endcase
      roll = $urandom_range(99, 0);
      op   = (roll < join_pct) ? OP_JOIN : OP_GET;
      if ($urandom_range(99, 0) < BAD_PCT) begin
        service = SERVICE_W'($urandom_range(SERVICE_MAX, SERVICES));
      end else if (mode != MODE_MIXED && $urandom_range(99, 0) < 85) begin
        service = focus_service;
      end else begin
        service = SERVICE_W'($urandom_range(SERVICES - 1, 0));
      end
      if (mode == MODE_FILL && $urandom_range(99, 0) < 85) begin
        vip = focus_vip;
      end else begin
        vip = 1'($urandom_range(1, 0));
      end
      push_request(op, service, vip, (n >= CALM_FROM) && (n < CALM_TO));
    end
    s_axis_tvalid_i <= 1'b0;

    // drain, then give the unit time to show any stray beat
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: random ready, one long hold-off to back up the input
  initial begin
    int unsigned sink_cycle;
    sink_cycle = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      sink_cycle++;
      if (sink_cycle == HOLD_AT) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        sink_cycle += HOLD_LEN;
      end else if (sink_cycle >= SINK_CALM_LO && sink_cycle < SINK_CALM_HI) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
